// ===== hdl/assert_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MNTCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MNTCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mntcr_pkg.sv =====
package mntcr_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 80;

  localparam logic [1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [1:0] EV_CC       = 2'd2;

  localparam logic       KIND_EVENT = 1'b0;
  localparam logic       KIND_START = 1'b1;

  localparam logic       ST_EVENT    = 1'b0;
  localparam logic       ST_POLY_ERR = 1'b1;

  localparam logic       REG_MASK   = 1'b0;
  localparam logic       REG_BUDGET = 1'b1;

  localparam logic [6:0] CC_LIMIT   = 7'd120;
  localparam logic [1:0] GEN_MARK   = 2'b01;
  localparam logic [4:0] BUDGET_MAX = 5'd16;

  typedef struct packed {
    logic       valid;
    logic [3:0] chan;
  } map_entry_t;

  typedef struct packed {
    logic [29:0] cnt;
    logic [3:0]  chan;
    logic [6:0]  note;
  } slot_t;

  typedef struct packed {
    logic [13:0] wide;
    logic [6:0]  second;
    logic [6:0]  first;
    logic [1:0]  etype;
    logic [3:0]  src;
  } in_item_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [6:0]  owner_note;
    logic [3:0]  owner_chan;
    logic [13:0] wide;
    logic [6:0]  second;
    logic [6:0]  first;
    logic [1:0]  otype;
    logic [3:0]  mapped;
  } out_item_t;

endpackage

// ===== hdl/midi_note_tracker_channel_remap_unit.sv =====
// MIDI note tracker with channel remap. A start item (in_tuser = 1) clears all
// held notes, the event counter and the failure flag, and rebuilds the channel
// map from the mask and budget registers one source channel per cycle. A
// note-on or note-off walks the slot RAM one entry per cycle with a single
// compare unit. One item is worked on at a time; the result register lets the
// next item enter while a result still waits on out_tready. After a polyphony
// error every event is ignored until the next start item.
`include "assert_macros.svh"

module midi_note_tracker_channel_remap_unit
  import mntcr_pkg::*;
  #(parameter int HELD_SLOTS = 32)
  (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // source_channel, event_type, first_data, second_data, wide_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // mapped_channel, out_type, out_first, out_second, out_wide,
  // owner_channel, owner_note, owner_generation
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_wdata
);

  localparam int SW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(HELD_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_DECIDE, S_SCAN, S_FINISH, S_EMIT
  } state_t;

  state_t      state_r;
  logic [15:0] mask_r;
  logic [4:0]  budget_r;
  in_item_t    in_item;
  logic [3:0]  src_r;
  logic [1:0]  type_r;
  logic [6:0]  d1_r;
  logic [6:0]  d2_r;
  logic [13:0] wide_r;
  logic [29:0] cnt_r;
  logic        failed_r;
  logic [HELD_SLOTS-1:0] vld_r;
  logic        issue_r;
  logic [SW-1:0] addr_r;
  logic        cmp_r;
  logic [SW-1:0] kidx_r;
  logic        found_r;
  logic [SW-1:0] best_r;
  logic [29:0] best_cnt_r;
  logic        pend_err_r;
  logic [3:0]  pend_map_r;
  logic [31:0] pend_gen_r;
  logic        out_vld_r;
  logic        out_status_r;
  out_item_t   out_r;

  map_entry_t  map_ent;
  logic        map_busy;
  logic        build;
  slot_t       rd_slot;
  slot_t       wr_slot;
  logic        ram_we;
  logic        ram_re;

  assign in_item   = in_tdata[$bits(in_item_t)-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign build     = in_tvalid && in_tready && (in_tuser == KIND_START);

  assign ram_re  = (state_r == S_SCAN) && issue_r;
  assign ram_we  = (state_r == S_FINISH) && (type_r == EV_NOTE_ON) && found_r;
  assign wr_slot = '{cnt: cnt_r, chan: src_r, note: d1_r};

  mntcr_chmap u_chmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .build  (build),
    .mask   (mask_r),
    .budget (budget_r),
    .src    (src_r),
    .entry  (map_ent),
    .busy   (map_busy)
  );

  mntcr_ram #(.WIDTH($bits(slot_t)), .DEPTH(HELD_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_r),
    .wdata (wr_slot),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (rd_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mask_r   <= '0;
      budget_r <= BUDGET_MAX;
      cnt_r    <= '0;
      failed_r <= 1'b0;
      vld_r    <= '0;
      issue_r  <= 1'b0;
      cmp_r    <= 1'b0;
      found_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MASK:   mask_r   <= cfg_wdata;
          REG_BUDGET: budget_r <= cfg_wdata[4:0];
          default:    mask_r   <= mask_r;
        endcase
      end
      if (out_vld_r && out_tready && (state_r != S_EMIT)) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            src_r  <= in_item.src;
            type_r <= in_item.etype;
            d1_r   <= in_item.first;
            d2_r   <= in_item.second;
            wide_r <= in_item.wide;
            if (in_tuser == KIND_START) begin
              vld_r    <= '0;
              cnt_r    <= '0;
              failed_r <= 1'b0;
              state_r  <= S_MAP;
            end else begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_MAP: begin
          if (!map_busy) begin
            state_r <= S_IDLE;
          end
        end
        S_DECIDE: begin
          if (failed_r) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r      <= cnt_r + 30'd1;
            pend_err_r <= ST_EVENT;
            pend_map_r <= map_ent.chan;
            pend_gen_r <= {GEN_MARK, cnt_r + 30'd1};
            found_r    <= 1'b0;
            issue_r    <= 1'b1;
            addr_r     <= '0;
            cmp_r      <= 1'b0;
            priority if (!map_ent.valid || (type_r == EV_CC && d1_r >= CC_LIMIT)) begin
              state_r <= S_IDLE;
            end else if (type_r == EV_NOTE_ON || type_r == EV_NOTE_OFF) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          cmp_r  <= issue_r;
          kidx_r <= addr_r;
          if (issue_r) begin
            addr_r <= addr_r + 1'b1;
            if (addr_r == LAST_SLOT) begin
              issue_r <= 1'b0;
            end
          end
          if (cmp_r) begin
            if (type_r == EV_NOTE_ON) begin
              if (!vld_r[kidx_r] && !found_r) begin
                found_r <= 1'b1;
                best_r  <= kidx_r;
              end
            end else if (vld_r[kidx_r] && rd_slot.chan == src_r && rd_slot.note == d1_r &&
                         (!found_r || rd_slot.cnt < best_cnt_r)) begin
              found_r    <= 1'b1;
              best_r     <= kidx_r;
              best_cnt_r <= rd_slot.cnt;
            end
            if (kidx_r == LAST_SLOT) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (type_r == EV_NOTE_ON) begin
            if (found_r) begin
              vld_r[best_r] <= 1'b1;
            end else begin
              failed_r   <= 1'b1;
              pend_err_r <= ST_POLY_ERR;
            end
            state_r <= S_EMIT;
          end else if (found_r) begin
            vld_r[best_r] <= 1'b0;
            pend_gen_r    <= {GEN_MARK, best_cnt_r};
            state_r       <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r    <= 1'b1;
            out_status_r <= pend_err_r;
            if (pend_err_r == ST_POLY_ERR) begin
              out_r <= '0;
            end else begin
              out_r <= '{gen: pend_gen_r, owner_note: d1_r, owner_chan: src_r,
                         wide: wide_r, second: d2_r, first: d1_r, otype: type_r,
                         mapped: pend_map_r};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(out_item_t))'(0), out_r};

  `MNTCR_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser == ST_POLY_ERR, out_tdata == '0, "error item carries payload")
  `MNTCR_ASSERT_IMP(a_gen_mark, out_tvalid && out_tuser == ST_EVENT, out_r.gen[31:30] == GEN_MARK, "generation mark missing")
  `MNTCR_ASSERT_NEXT(a_scan_hold, state_r == S_SCAN, $stable(vld_r), "slot valid bits changed during scan")
  `MNTCR_ASSERT_IMP(a_fail_emit, $rose(failed_r), state_r == S_EMIT && pend_err_r == ST_POLY_ERR, "failure without error item")

endmodule

// ===== hdl/mntcr_ram.sv =====
module mntcr_ram
  #(parameter int WIDTH = 41,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mntcr_chmap.sv =====
module mntcr_chmap
  import mntcr_pkg::*;
  (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       build,
  input  logic [15:0] mask,
  input  logic [4:0] budget,
  input  logic [3:0] src,
  output map_entry_t entry,
  output logic       busy
);

  map_entry_t map_r [NUM_CHANNELS];
  logic [15:0] mask_r;
  logic [4:0]  limit_r;
  logic [4:0]  limit_nxt;
  logic [4:0]  used_r;
  logic [3:0]  idx_r;
  logic        busy_r;

  always_comb begin
    priority if (budget == 5'd0) begin
      limit_nxt = 5'd1;
    end else if (budget > BUDGET_MAX) begin
      limit_nxt = BUDGET_MAX;
    end else begin
      limit_nxt = budget;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        map_r[i] <= '0;
      end
    end else if (build) begin
      mask_r  <= mask;
      limit_r <= limit_nxt;
      used_r  <= '0;
      idx_r   <= '0;
      busy_r  <= 1'b1;
    end else if (busy_r) begin
      if (mask_r[idx_r] && (used_r < limit_r)) begin
        map_r[idx_r] <= '{valid: 1'b1, chan: used_r[3:0]};
        used_r       <= used_r + 5'd1;
      end else begin
        map_r[idx_r] <= '0;
      end
      idx_r <= idx_r + 4'd1;
      if (idx_r == 4'(NUM_CHANNELS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign entry = map_r[src];
  assign busy  = busy_r;

endmodule
